### rtl/bdq_pkg.sv
// Package for the bounded deque: action codes, controller state type, reset
// capacity and field widths. No dependencies; the top level and testbench import it.
`default_nettype none

package bdq_pkg;

    // Widths of the stream and register fields
    localparam int unsigned ActionW = 3;
    localparam int unsigned WordW   = 32;
    localparam int unsigned CapW    = 11;

    // Capacity after reset
    localparam logic [CapW-1:0] CapReset = 11'd1024;

    // Action codes carried on the input tuser
    typedef enum logic [ActionW-1:0] {
        ACT_QUERY      = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_PUSH_REAR  = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_POP_REAR   = 3'd4
    } t_action;

    // Controller states
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } t_state;

endpackage

`default_nettype wire

### rtl/bdq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bdq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire  [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire  [WIDTH-1:0]          i_wdata,
    input  wire                       i_re,
    input  wire  [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/bounded_double_ended_queue_unit.sv
// Top level of the bounded deque: ring of words in bdq_ram, end pointers,
// occupancy, cached end words, stream ports and the capacity register.
// Depends on bdq_pkg and bdq_ram.
`default_nettype none

// Channel  | Dir | Handshake            | Payload
// ---------+-----+----------------------+------------------------------------------
// input    | in  | i_s_tvalid/o_s_tready| tuser: action; tdata: data_value
// result   | out | o_m_tvalid/i_m_tready| tdata: accepted, front, rear, empty, full
// config   | in  | psel/penable/pready  | reg 0 at byte 0: capacity (11 bits)
//
// Queries, pushes, refused actions and pops that leave fewer than two entries
// are answered without a RAM read. A pop that leaves two or more entries
// reads the new end word from the single RAM read port in the READ state.
// Reset is synchronous and clears pointers, occupancy and capacity to 1024;
// the RAM is not cleared. A new item is taken in the idle state while the result
// slot is empty or drained in the same cycle; a stalled result holds the input.

module bounded_double_ended_queue_unit #(
    parameter int unsigned DEPTH = 1024
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // input stream
    input  wire                            i_s_tvalid,
    output logic                           o_s_tready,
    input  wire  [31:0]                    i_s_tdata,  // [31:0] data_value
    input  wire  [bdq_pkg::ActionW-1:0]    i_s_tuser,  // [2:0] action
    // result stream
    output logic                           o_m_tvalid,
    input  wire                            i_m_tready,
    // [0] accepted, [32:1] front_value, [64:33] rear_value,
    // [65] now_empty, [66] now_full, [71:67] zero
    output logic [71:0]                    o_m_tdata,
    // configuration
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [1:0]                     paddr,
    input  wire  [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    import bdq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned OW = $clog2(DEPTH + 1);
    localparam int unsigned CW = (OW > CapW) ? OW : CapW;
    localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DepthC  = CW'(DEPTH);

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        ring_next = (idx == LastIdx) ? '0 : idx + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] idx);
        ring_prev = (idx == '0) ? LastIdx : idx - AW'(1);
    endfunction

    // State registers
    t_state           r_state,  n_state;
    logic [AW-1:0]    r_front,  n_front;
    logic [AW-1:0]    r_rear,   n_rear;
    logic [OW-1:0]    r_occ,    n_occ;
    logic [WordW-1:0] r_fval,   n_fval;
    logic [WordW-1:0] r_rval,   n_rval;
    logic             r_pend_front, n_pend_front;
    logic             r_acc,    n_acc;
    logic             r_ovalid, n_ovalid;
    logic [CapW-1:0]  r_cap;

    // RAM ports
    logic             we, re;
    logic [AW-1:0]    waddr, raddr;
    logic [WordW-1:0] rdata;

    logic             in_xfer;
    logic             is_full, is_empty;
    logic [CW-1:0]    eff_cap;
    t_action          act;

    bdq_ram #(
        .WIDTH (WordW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_s_tdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Capacity saturates at the ring depth
    assign eff_cap  = (CW'(r_cap) > DepthC) ? DepthC : CW'(r_cap);
    assign is_full  = CW'(r_occ) >= eff_cap;
    assign is_empty = (r_occ == '0);

    assign act        = t_action'(i_s_tuser);
    assign o_s_tready = (r_state == ST_IDLE) && (!r_ovalid || i_m_tready);
    assign in_xfer    = i_s_tvalid && o_s_tready;

    // Result bus, taken from the state left by the last item
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'b0, is_full, is_empty,
                         is_empty ? {WordW{1'b1}} : r_rval,
                         is_empty ? {WordW{1'b1}} : r_fval,
                         r_acc};

    // Next state and RAM control
    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_rear       = r_rear;
        n_occ        = r_occ;
        n_fval       = r_fval;
        n_rval       = r_rval;
        n_pend_front = r_pend_front;
        n_acc        = r_acc;
        n_ovalid     = r_ovalid && !i_m_tready;
        we           = 1'b0;
        waddr        = r_rear;
        re           = 1'b0;
        raddr        = ring_next(r_front);

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_acc    = 1'b1;
                    n_ovalid = 1'b1;
                    case (act)
                        ACT_PUSH_FRONT: begin
                            if (is_full) begin
                                n_acc = 1'b0;
                            end else begin
                                n_front = ring_prev(r_front);
                                we      = 1'b1;
                                waddr   = ring_prev(r_front);
                                n_occ   = r_occ + OW'(1);
                                n_fval  = i_s_tdata;
                                if (is_empty) begin
                                    n_rval = i_s_tdata;
                                end
                            end
                        end
                        ACT_PUSH_REAR: begin
                            if (is_full) begin
                                n_acc = 1'b0;
                            end else begin
                                n_rear = ring_next(r_rear);
                                we     = 1'b1;
                                waddr  = r_rear;
                                n_occ  = r_occ + OW'(1);
                                n_rval = i_s_tdata;
                                if (is_empty) begin
                                    n_fval = i_s_tdata;
                                end
                            end
                        end
                        ACT_POP_FRONT: begin
                            if (is_empty) begin
                                n_acc = 1'b0;
                            end else begin
                                n_front = ring_next(r_front);
                                n_occ   = r_occ - OW'(1);
                                if (r_occ == OW'(2)) begin
                                    n_fval = r_rval;
                                end else if (r_occ > OW'(2)) begin
                                    // fetch the new front word
                                    re           = 1'b1;
                                    raddr        = ring_next(r_front);
                                    n_pend_front = 1'b1;
                                    n_ovalid     = 1'b0;
                                    n_state      = ST_READ;
                                end
                            end
                        end
                        ACT_POP_REAR: begin
                            if (is_empty) begin
                                n_acc = 1'b0;
                            end else begin
                                n_rear = ring_prev(r_rear);
                                n_occ  = r_occ - OW'(1);
                                if (r_occ == OW'(2)) begin
                                    n_rval = r_fval;
                                end else if (r_occ > OW'(2)) begin
                                    // fetch the new rear word
                                    re           = 1'b1;
                                    raddr        = ring_prev(ring_prev(r_rear));
                                    n_pend_front = 1'b0;
                                    n_ovalid     = 1'b0;
                                    n_state      = ST_READ;
                                end
                            end
                        end
                        default: begin
                            // query and unused codes change nothing
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (r_pend_front) begin
                    n_fval = rdata;
                end else begin
                    n_rval = rdata;
                end
                n_ovalid = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_front  <= '0;
            r_rear   <= '0;
            r_occ    <= '0;
            r_acc    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_front  <= n_front;
            r_rear   <= n_rear;
            r_occ    <= n_occ;
            r_acc    <= n_acc;
            r_ovalid <= n_ovalid;
        end
    end

    // Cached end words
    always_ff @(posedge i_clk) begin
        r_fval       <= n_fval;
        r_rval       <= n_rval;
        r_pend_front <= n_pend_front;
    end

    // Configuration register: word index is paddr[1]
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CapReset;
        end else if (psel && penable && pwrite && pready && !paddr[1]) begin
            r_cap <= pwdata[CapW-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[1] ? 32'd0 : {{(32 - CapW){1'b0}}, r_cap};

endmodule

`default_nettype wire

### test/tb_bounded_double_ended_queue_unit.sv
// Self-checking testbench for bounded_double_ended_queue_unit: drives the action
// stream and the APB capacity register and checks every result transfer against
// a predicted deque status. Depends on bdq_pkg and the deque RTL.
`timescale 1ns / 1ps

module tb_bounded_double_ended_queue_unit;
    import bdq_pkg::*;

    localparam int unsigned RING_DEPTH = 1024;
    localparam logic [1:0] CAP_ADDR = 2'd0;
    // codes outside the defined set behave as a query
    localparam logic [ActionW-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ActionW-1:0] ACT_SPARE_HI = 3'd7;

    // Expected status after one action
    typedef struct {
        logic        ok;
        logic [31:0] front;
        logic [31:0] rear;
        logic        empty;
        logic        full;
    } t_deque_status;

    // Deque status predictor and the store of statuses still owed by the block
    class deque_scoreboard;
        logic [31:0]   ring [RING_DEPTH];
        int unsigned   head_slot;
        int unsigned   tail_slot;
        int unsigned   fill;
        int unsigned   capacity;
        t_deque_status status_due [$];
        int unsigned   mismatches;
        int unsigned   refused;
        int unsigned   full_seen;
        int unsigned   deepest;

        function new();
            head_slot  = 0;
            tail_slot  = 0;
            fill       = 0;
            capacity   = CapReset;
            mismatches = 0;
            refused    = 0;
            full_seen  = 0;
            deepest    = 0;
        endfunction

        function int unsigned slot_after(int unsigned s);
            return (s + 1 >= RING_DEPTH) ? 0 : s + 1;
        endfunction

        function int unsigned slot_before(int unsigned s);
            return (s == 0) ? RING_DEPTH - 1 : s - 1;
        endfunction

        // capacity saturates at the ring depth
        function bit at_limit();
            return fill >= ((capacity > RING_DEPTH) ? RING_DEPTH : capacity);
        endfunction

        function void set_capacity(logic [CapW-1:0] value);
            capacity = value;
        endfunction

        // Apply one accepted action and queue the status it must produce
        function void apply_action(logic [ActionW-1:0] act, logic [31:0] word);
            t_deque_status st;
            st.ok = 1'b1;
            case (act)
                ACT_PUSH_FRONT: begin
                    if (at_limit()) begin
                        st.ok = 1'b0;
                    end else begin
                        head_slot = slot_before(head_slot);
                        ring[head_slot] = word;
                        fill++;
                    end
                end
                ACT_PUSH_REAR: begin
                    if (at_limit()) begin
                        st.ok = 1'b0;
                    end else begin
                        ring[tail_slot] = word;
                        tail_slot = slot_after(tail_slot);
                        fill++;
                    end
                end
                ACT_POP_FRONT: begin
                    if (fill == 0) begin
                        st.ok = 1'b0;
                    end else begin
                        head_slot = slot_after(head_slot);
                        fill--;
                    end
                end
                ACT_POP_REAR: begin
                    if (fill == 0) begin
                        st.ok = 1'b0;
                    end else begin
                        tail_slot = slot_before(tail_slot);
                        fill--;
                    end
                end
                default: begin
                end
            endcase
            st.empty = (fill == 0);
            st.full  = at_limit();
            st.front = st.empty ? '1 : ring[head_slot];
            st.rear  = st.empty ? '1 : ring[slot_before(tail_slot)];
            if (!st.ok) refused++;
            if (st.full) full_seen++;
            if (fill > deepest) deepest = fill;
            status_due.push_back(st);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in %s: expected %h, got %h", name, want, got);
            end
        endfunction

        // Compare one result transfer with the oldest owed status
        function void compare_status(logic [71:0] beat);
            t_deque_status want;
            if (status_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer %h", beat);
                return;
            end
            want = status_due.pop_front();
            check_field("accepted", want.ok, beat[0]);
            check_field("front_value", want.front, beat[32:1]);
            check_field("rear_value", want.rear, beat[64:33]);
            check_field("now_empty", want.empty, beat[65]);
            check_field("now_full", want.full, beat[66]);
            check_field("padding", '0, beat[71:67]);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [31:0]       i_s_tdata;   // [31:0] data_value
    logic [ActionW-1:0] i_s_tuser;  // [2:0] action
    logic              o_m_tvalid;
    logic              i_m_tready;
    // [0] accepted, [32:1] front, [64:33] rear, [65] empty, [66] full, [71:67] zero
    logic [71:0]       o_m_tdata;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [1:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    deque_scoreboard sb = new();
    bit              calm;
    int unsigned     stall_left;
    int unsigned     items_sent;
    int unsigned     cap_settings;

    bounded_double_ended_queue_unit #(
        .DEPTH(RING_DEPTH)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 20 ns clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Result side: check each transfer, then stall for a random spell
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.compare_status(o_m_tdata);
            stall_left = calm ? 0 : $urandom_range(8);
        end
        if (stall_left != 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Hand one action to the block after a random gap
    task automatic send_item(logic [ActionW-1:0] act, logic [31:0] word);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(8);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= word;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.apply_action(act, word);
        items_sent++;
    endtask

    // Hold the input until every owed status has come back
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.status_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write of the capacity register followed by a read back
    task automatic write_capacity(logic [CapW-1:0] value);
        logic [31:0] noise;
        noise = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= {noise[31:CapW], value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_capacity(value);
        cap_settings++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.check_field("capacity readback", value, prdata[CapW-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly random words, now and then the extremes
    function automatic logic [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '1;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ActionW-1:0] pick_action(int unsigned push_pct,
                                                       int unsigned pop_pct);
        int unsigned r;
        r = $urandom_range(99);
        if (r < push_pct)
            return $urandom_range(1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
        if (r < push_pct + pop_pct)
            return $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_REAR;
        if ($urandom_range(3) == 0)
            return ActionW'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
        return ACT_QUERY;
    endfunction

    // Random mix with calm stretches where neither side idles
    task automatic run_mix(int unsigned count, int unsigned push_pct, int unsigned pop_pct);
        for (int unsigned i = 0; i < count; i++) begin
            calm = (i % 90) >= 70;
            send_item(pick_action(push_pct, pop_pct), pick_word());
        end
        calm = 1'b0;
    endtask

    // Limit on the whole run
    initial begin
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence
    initial begin
        int unsigned guard;
        int unsigned failures;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= ACT_QUERY;
        i_m_tready <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= CAP_ADDR;
        pwdata     <= '0;
        calm       = 1'b0;
        stall_left = 0;
        items_sent = 0;
        cap_settings = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed: empty refusals, extreme words at both ends, spare codes
        send_item(ACT_QUERY, 32'h1234_5678);
        send_item(ACT_POP_FRONT, '0);
        send_item(ACT_POP_REAR, '0);
        send_item(ACT_PUSH_FRONT, 32'h7FFF_FFFF);
        send_item(ACT_PUSH_REAR, 32'h8000_0000);
        send_item(ACT_PUSH_FRONT, '1);
        send_item(ACT_PUSH_REAR, '0);
        send_item(ACT_QUERY, '1);
        send_item(ACT_POP_FRONT, '1);
        send_item(ACT_POP_REAR, '1);
        for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
            send_item(ActionW'(a), pick_word());
        send_item(ACT_POP_FRONT, '0);
        send_item(ACT_POP_REAR, '0);
        send_item(ACT_POP_REAR, '0);
        wait_drained();

        // Capacity one: a single entry fills it
        write_capacity(11'd1);
        send_item(ACT_PUSH_REAR, pick_word());
        send_item(ACT_PUSH_FRONT, pick_word());
        send_item(ACT_POP_FRONT, '0);
        wait_drained();

        // Capacity zero: empty and full at once, every push refused
        write_capacity(11'd0);
        send_item(ACT_PUSH_FRONT, pick_word());
        send_item(ACT_QUERY, '0);
        wait_drained();

        // Largest register value saturates to the ring depth
        write_capacity(11'h7FF);
        send_item(ACT_PUSH_REAR, pick_word());
        send_item(ACT_POP_FRONT, '0);
        wait_drained();

        // Small capacity of six, pausing midway until drained
        write_capacity(11'd6);
        run_mix(70, 55, 35);
        wait_drained();
        run_mix(60, 45, 45);
        wait_drained();

        // Fill the whole ring, then keep hitting the full boundary
        write_capacity(11'd1024);
        guard = 0;
        while (!sb.at_limit() && guard < 1400) begin
            calm = (guard % 90) >= 70;
            send_item(pick_action(97, 2), pick_word());
            guard++;
        end
        calm = 1'b0;
        run_mix(30, 60, 30);
        wait_drained();

        // Capacity dropped below the fill: pushes refused, pops drain it
        write_capacity(11'd3);
        run_mix(80, 30, 60);
        wait_drained();

        write_capacity(CapW'($urandom_range(64, 1)));
        run_mix(60, 50, 40);
        wait_drained();

        write_capacity(11'd2);
        run_mix(50, 45, 45);
        wait_drained();
        repeat (8) @(posedge i_clk);

        failures = sb.mismatches + sb.status_due.size();
        $display("Summary: %0d actions under %0d capacity settings, %0d refused,",
                 items_sent, cap_settings, sb.refused);
        $display("         full status seen %0d times, deepest fill %0d entries.",
                 sb.full_seen, sb.deepest);
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### files.f
rtl/bdq_pkg.sv
rtl/bdq_ram.sv
rtl/bounded_double_ended_queue_unit.sv
test/tb_bounded_double_ended_queue_unit.sv
